// File: rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Shared widths, register indexes and beat types of the sphere-wall
// collision pipeline.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int unsigned QW = 53;  // dividend and quotient bits
  localparam int unsigned DW = 37;  // divisor bits

  typedef enum logic [2:0] {
    CFG_WALL_X = 3'd0,
    CFG_WALL_Y = 3'd1,
    CFG_WALL_Z = 3'd2,
    CFG_NORM_X = 3'd3,
    CFG_NORM_Y = 3'd4,
    CFG_NORM_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] wp_x;
    logic [31:0] wp_y;
    logic [31:0] wp_z;
    logic [15:0] n_x;
    logic [15:0] n_y;
    logic [15:0] n_z;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [30:0] radius;
    logic [30:0] growth_rate;
    logic [47:0] last_update_time;
  } in_t;

  typedef struct packed {
    logic        evt;
    logic [47:0] last;
    logic [31:0] nv_x;
    logic [31:0] nv_y;
    logic [31:0] nv_z;
  } side_t;

  typedef struct packed {
    logic [QW-1:0] dividend;
    logic [DW-1:0] divisor;
    side_t         side;
  } div_in_t;

  typedef struct packed {
    logic [QW-1:0] num;
    logic [DW-1:0] rem;
    logic [QW-1:0] quo;
    logic [DW-1:0] dvs;
    side_t         side;
  } div_stage_t;

  typedef struct packed {
    logic        event_valid;
    logic [47:0] event_time;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
  } out_t;

endpackage

// File: rtl/swc_in_if.sv
// ----------------------------------------------------------------------------
// swc_in_if
// Sphere input channel: one sphere state per beat.
// ----------------------------------------------------------------------------
interface swc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [30:0] radius;
  logic [30:0] growth_rate;
  logic [47:0] last_update_time;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, growth_rate,
           last_update_time,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, growth_rate,
           last_update_time,
    output ready
  );
endinterface

// File: rtl/swc_out_if.sv
// ----------------------------------------------------------------------------
// swc_out_if
// Collision result channel: one prediction per beat.
// ----------------------------------------------------------------------------
interface swc_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic [47:0] event_time;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic [31:0] new_vel_z;

  modport source (
    output valid, event_valid, event_time, new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );
  modport sink (
    input  valid, event_valid, event_time, new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface

// File: rtl/sphere_wall_collision_core.sv
// ----------------------------------------------------------------------------
// sphere_wall_collision_core
// Predicts when a growing sphere meets a plane wall and gives its velocity
// after the bounce.
// ----------------------------------------------------------------------------
// Spheres arrive as beats on in_if and one result per sphere leaves on out_if
// in the same order. The wall point and normal are written through the
// cfg_we_i / cfg_idx_i / cfg_wdata_i port; the user must write them only
// while no sphere is in flight, which the block does not enforce. An unused
// index is ignored. The pipeline takes one beat per cycle while in_if.ready
// is high. From acceptance to the output register a beat passes five stages
// of dot products and velocity arithmetic, 53 restoring divider stages (one
// quotient bit each, set by the 53-bit dividend), and one time-add stage.
// Reset clears every valid bit and loads the wall registers with a wall
// through the origin facing plus x. When the receiver holds ready low, the
// output register keeps its beat and a one-beat skid register catches the
// next one; the whole pipeline then freezes and in_if.ready drops until the
// skid register drains, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sphere_wall_collision_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  swc_in_if.sink      in_if,
  swc_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import swc_pkg::*;

  cfg_t       cfg_q;
  in_t        in_data;
  logic       en;
  logic       f_valid;
  div_in_t    f_data;
  logic       d_valid;
  logic [QW-1:0] d_quo;
  side_t      d_side;
  logic [47:0] q_sat;
  logic [48:0] t_sum;
  out_t       p_data;
  out_t       out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wp_x <= '0;
      cfg_q.wp_y <= '0;
      cfg_q.wp_z <= '0;
      cfg_q.n_x  <= 16'd16384;
      cfg_q.n_y  <= '0;
      cfg_q.n_z  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WALL_X: cfg_q.wp_x <= cfg_wdata_i;
        CFG_WALL_Y: cfg_q.wp_y <= cfg_wdata_i;
        CFG_WALL_Z: cfg_q.wp_z <= cfg_wdata_i;
        CFG_NORM_X: cfg_q.n_x  <= cfg_wdata_i[15:0];
        CFG_NORM_Y: cfg_q.n_y  <= cfg_wdata_i[15:0];
        CFG_NORM_Z: cfg_q.n_z  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign en          = !skid_valid_q;
  assign in_if.ready = en;

  always_comb begin
    in_data.pos_x            = in_if.pos_x;
    in_data.pos_y            = in_if.pos_y;
    in_data.pos_z            = in_if.pos_z;
    in_data.vel_x            = in_if.vel_x;
    in_data.vel_y            = in_if.vel_y;
    in_data.vel_z            = in_if.vel_z;
    in_data.radius           = in_if.radius;
    in_data.growth_rate      = in_if.growth_rate;
    in_data.last_update_time = in_if.last_update_time;
  end

  swc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_if.valid),
    .data_i  (in_data),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  swc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .data_i  (f_data),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  always_comb begin
    q_sat = (d_quo[QW-1:48] != '0) ? 48'hffff_ffff_ffff : d_quo[47:0];
    t_sum = {1'b0, q_sat} + {1'b0, d_side.last};
    p_data.event_valid = d_side.evt;
    p_data.event_time  = !d_side.evt ? '0 :
                         (t_sum[48] ? 48'hffff_ffff_ffff : t_sum[47:0]);
    p_data.new_vel_x   = d_side.nv_x;
    p_data.new_vel_y   = d_side.nv_y;
    p_data.new_vel_z   = d_side.nv_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (out_valid_q && !out_if.ready) begin
        skid_valid_q <= d_valid;
      end else begin
        out_valid_q <= d_valid;
      end
    end else if (out_if.ready) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_valid_q && !out_if.ready) begin
        skid_q <= p_data;
      end else begin
        out_q <= p_data;
      end
    end else if (out_if.ready) begin
      out_q <= skid_q;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.event_valid = out_q.event_valid;
  assign out_if.event_time  = out_q.event_time;
  assign out_if.new_vel_x   = out_q.new_vel_x;
  assign out_if.new_vel_y   = out_q.new_vel_y;
  assign out_if.new_vel_z   = out_q.new_vel_z;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds a beat while the output register is empty.");

  a_skid_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !in_if.ready)
    else $error("Input accepted while the skid register is full.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready && skid_valid_q) |=> (out_valid_q && skid_valid_q))
    else $error("A stalled result was dropped.");

  a_no_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.event_valid) |-> (out_q.event_time == '0))
    else $error("Event time is nonzero without a predicted event.");
`endif

endmodule

// File: rtl/swc_front.sv
// ----------------------------------------------------------------------------
// swc_front
// Five register stages: offsets, dot products, gap and rate, reflection
// products, and the saturated post-collision velocity with divider operands.
// ----------------------------------------------------------------------------
module swc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  swc_pkg::cfg_t    cfg_i,
  input  logic             valid_i,
  input  swc_pkg::in_t     data_i,
  output logic             valid_o,
  output swc_pkg::div_in_t data_o
);
  import swc_pkg::*;

  logic signed [15:0] nrm [3];
  logic signed [31:0] wall [3];
  logic signed [31:0] pin [3];
  logic signed [31:0] vin [3];

  logic [4:0] vld_q;

  logic signed [32:0] d1_q [3];
  logic signed [31:0] v1_q [3];
  logic [30:0]        rad1_q, gr1_q;
  logic [47:0]        last1_q;

  logic signed [48:0] po2_q [3];
  logic signed [47:0] pv2_q [3];
  logic signed [47:0] gn2_q [3];
  logic signed [31:0] v2_q [3];
  logic [30:0]        rad2_q, gr2_q;
  logic [47:0]        last2_q;

  logic signed [51:0] gap_raw;
  logic signed [50:0] rate_raw;
  logic signed [49:0] dv_raw;
  logic signed [37:0] gap3_q;
  logic signed [36:0] rate3_q;
  logic signed [35:0] vn3_q;
  logic signed [47:0] gn3_q [3];
  logic signed [31:0] v3_q [3];
  logic [47:0]        last3_q;

  logic signed [37:0] k3;
  logic               evt3;
  logic signed [53:0] kn4_q [3];
  logic signed [47:0] gn4_q [3];
  logic signed [31:0] v4_q [3];
  logic [47:0]        last4_q;
  logic               evt4_q;
  logic [QW-1:0]      dvd4_q;
  logic [DW-1:0]      dvs4_q;

  logic signed [55:0] acc [3];
  logic [31:0]        nv [3];
  div_in_t            out_q;

  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    logic [31:0] r;
    if (v[41:31] == {11{v[31]}}) begin
      r = v[31:0];
    end else if (v[41]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  always_comb begin
    nrm[0]  = cfg_i.n_x;
    nrm[1]  = cfg_i.n_y;
    nrm[2]  = cfg_i.n_z;
    wall[0] = cfg_i.wp_x;
    wall[1] = cfg_i.wp_y;
    wall[2] = cfg_i.wp_z;
    pin[0]  = data_i.pos_x;
    pin[1]  = data_i.pos_y;
    pin[2]  = data_i.pos_z;
    vin[0]  = data_i.vel_x;
    vin[1]  = data_i.vel_y;
    vin[2]  = data_i.vel_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_comb begin
    gap_raw  = 52'(po2_q[0]) + 52'(po2_q[1]) + 52'(po2_q[2])
             - 52'({1'b0, rad2_q, 14'b0});
    rate_raw = 51'(pv2_q[0]) + 51'(pv2_q[1]) + 51'(pv2_q[2])
             - 51'({1'b0, gr2_q, 14'b0});
    dv_raw   = 50'(pv2_q[0]) + 50'(pv2_q[1]) + 50'(pv2_q[2]);
    k3       = vn3_q[35] ? -(38'(vn3_q) <<< 1) : '0;
    evt3     = !gap3_q[37] && (gap3_q != '0) && rate3_q[36];
    for (int i = 0; i < 3; i++) begin
      acc[i] = (56'(v4_q[i]) <<< 14) + 56'(gn4_q[i]) + 56'(kn4_q[i]);
      nv[i]  = sat32(acc[i][55:14]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i]  <= 33'(pin[i]) - 33'(wall[i]);
        v1_q[i]  <= vin[i];
        po2_q[i] <= 49'(d1_q[i]) * 49'(nrm[i]);
        pv2_q[i] <= 48'(v1_q[i]) * 48'(nrm[i]);
        gn2_q[i] <= 48'($signed({1'b0, gr1_q})) * 48'(nrm[i]);
        v2_q[i]  <= v1_q[i];
        gn3_q[i] <= gn2_q[i];
        v3_q[i]  <= v2_q[i];
        kn4_q[i] <= 54'(k3) * 54'(nrm[i]);
        gn4_q[i] <= gn3_q[i];
        v4_q[i]  <= v3_q[i];
      end
      rad1_q  <= data_i.radius;
      gr1_q   <= data_i.growth_rate;
      last1_q <= data_i.last_update_time;
      rad2_q  <= rad1_q;
      gr2_q   <= gr1_q;
      last2_q <= last1_q;
      gap3_q  <= gap_raw[51:14];
      rate3_q <= rate_raw[50:14];
      vn3_q   <= dv_raw[49:14];
      last3_q <= last2_q;
      last4_q <= last3_q;
      evt4_q  <= evt3;
      dvd4_q  <= evt3 ? {gap3_q[36:0], 16'b0} : '0;
      dvs4_q  <= evt3 ? (~rate3_q + 37'd1) : DW'(1);
      out_q.dividend  <= dvd4_q;
      out_q.divisor   <= dvs4_q;
      out_q.side.evt  <= evt4_q;
      out_q.side.last <= last4_q;
      out_q.side.nv_x <= nv[0];
      out_q.side.nv_y <= nv[1];
      out_q.side.nv_z <= nv[2];
    end
  end

  assign valid_o = vld_q[4];
  assign data_o  = out_q;

endmodule

// File: rtl/swc_divider.sv
// ----------------------------------------------------------------------------
// swc_divider
// Pipelined restoring divider, one quotient bit per register stage; the
// sideband of each beat travels with its operands.
// ----------------------------------------------------------------------------
module swc_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  swc_pkg::div_in_t data_i,
  output logic             valid_o,
  output logic [swc_pkg::QW-1:0] quo_o,
  output swc_pkg::side_t   side_o
);
  import swc_pkg::*;

  div_stage_t stg   [QW+1];
  logic       vld   [QW+1];

  assign stg[0].num  = data_i.dividend;
  assign stg[0].rem  = '0;
  assign stg[0].quo  = '0;
  assign stg[0].dvs  = data_i.divisor;
  assign stg[0].side = data_i.side;
  assign vld[0]      = valid_i;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] rem_s;
    logic        ge;
    div_stage_t  nxt;
    div_stage_t  st_q;
    logic        v_q;

    always_comb begin
      rem_s    = {stg[k].rem, stg[k].num[QW-1]};
      ge       = rem_s >= {1'b0, stg[k].dvs};
      nxt      = stg[k];
      nxt.num  = {stg[k].num[QW-2:0], 1'b0};
      nxt.quo  = {stg[k].quo[QW-2:0], ge};
      nxt.rem  = ge ? DW'(rem_s - {1'b0, stg[k].dvs}) : rem_s[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q <= nxt;
      end
    end

    assign stg[k+1] = st_q;
    assign vld[k+1] = v_q;
  end

  assign valid_o = vld[QW];
  assign quo_o   = stg[QW].quo;
  assign side_o  = stg[QW].side;

endmodule
